@@ hdl/mrpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared constants and types for the Miller-Rabin prime test unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mrpt_pkg;
	localparam int unsigned ValueWidth = 32;
	localparam int unsigned NumBases   = 5;
	localparam int unsigned BaseIdxW   = 3;
	localparam int unsigned QueueDepth = 2;

	// witness bases in test order
	function automatic logic [8:0] base_value(input logic [BaseIdxW-1:0] idx);
		logic [8:0] v;
		case (idx)
			3'd0:    v = 9'd2;
			3'd1:    v = 9'd3;
			3'd2:    v = 9'd5;
			3'd3:    v = 9'd233;
			default: v = 9'd331;
		endcase
		return v;
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE,
		ST_REDUCE,
		ST_EXP_MUL,
		ST_EXP_SQR,
		ST_CHECK,
		ST_SQR_LOOP,
		ST_VERDICT,
		ST_DONE
	} eng_state_t;

	typedef enum logic [1:0] {
		CLS_COMPOSITE,
		CLS_PRIME,
		CLS_TEST
	} cls_t;
endpackage
`default_nettype wire

@@ hdl/mrpt_stream_if.sv @@
// ----------------------------------------------------------------------------
// mrpt_stream_if
// Valid/ready channel with a payload of parametric width.
// ----------------------------------------------------------------------------
`default_nettype none
interface mrpt_stream_if #(
	parameter int unsigned W = 32
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/mrpt_front.sv @@
// ----------------------------------------------------------------------------
// mrpt_front
// Accepts candidates, settles the trivial cases and queues work for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_front #(
	parameter int unsigned VALUE_WIDTH = mrpt_pkg::ValueWidth
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [VALUE_WIDTH-1:0] in_value,
	output logic                        q_valid,
	input  wire logic                   q_ready,
	output logic [VALUE_WIDTH-1:0]      q_value,
	output mrpt_pkg::cls_t              q_cls
);
	localparam int unsigned Depth = mrpt_pkg::QueueDepth;

	logic [VALUE_WIDTH-1:0] val_q [Depth];
	mrpt_pkg::cls_t         cls_q [Depth];
	logic                   wr_ptr_q, rd_ptr_q;
	logic [1:0]             count_q;
	mrpt_pkg::cls_t         cls_in;
	logic                   push, pop;

	// classify: below two or even (except two) is composite
	always_comb begin
		if (in_value < VALUE_WIDTH'(2))
			cls_in = mrpt_pkg::CLS_COMPOSITE;
		else if (in_value == VALUE_WIDTH'(2))
			cls_in = mrpt_pkg::CLS_PRIME;
		else if (!in_value[0])
			cls_in = mrpt_pkg::CLS_COMPOSITE;
		else
			cls_in = mrpt_pkg::CLS_TEST;
	end

	assign in_ready = (count_q != 2'(Depth));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_value  = val_q[rd_ptr_q];
	assign q_cls    = cls_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wr_ptr_q] <= in_value;
			cls_q[wr_ptr_q] <= cls_in;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

@@ hdl/mrpt_mulmod.sv @@
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, shift and add.
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_mulmod #(
	parameter int unsigned VALUE_WIDTH = mrpt_pkg::ValueWidth
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] a,
	input  wire logic [VALUE_WIDTH-1:0] b,
	input  wire logic [VALUE_WIDTH-1:0] m,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      product
);
	logic [VALUE_WIDTH-1:0] a_q, b_q, acc_q;
	logic                   busy_q;
	logic [VALUE_WIDTH:0]   acc_sum, dbl_sum;
	logic [VALUE_WIDTH-1:0] acc_nxt, dbl_nxt;

	// modular add of two residues
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, a_q};
		dbl_sum = {1'b0, a_q} + {1'b0, a_q};
		acc_nxt = (acc_sum >= {1'b0, m}) ? VALUE_WIDTH'(acc_sum - {1'b0, m})
			: acc_sum[VALUE_WIDTH-1:0];
		dbl_nxt = (dbl_sum >= {1'b0, m}) ? VALUE_WIDTH'(dbl_sum - {1'b0, m})
			: dbl_sum[VALUE_WIDTH-1:0];
	end

	assign product = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) acc_q <= acc_nxt;
			a_q <= dbl_nxt;
			b_q <= b_q >> 1;
		end
	end

	// hold busy until b runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) busy_q <= 1'b1;
			else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/mrpt_engine.sv @@
// ----------------------------------------------------------------------------
// mrpt_engine
// Back part: runs the witness loop on one candidate using the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_engine #(
	parameter int unsigned VALUE_WIDTH = mrpt_pkg::ValueWidth
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	output logic                        q_ready,
	input  wire logic [VALUE_WIDTH-1:0] q_value,
	input  wire mrpt_pkg::cls_t         q_cls,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        out_is_prime
);
	localparam int unsigned BW = mrpt_pkg::BaseIdxW;

	mrpt_pkg::eng_state_t   state_q, state_d;
	logic [VALUE_WIDTH-1:0] p_q, pm1_q, s_q, e_q, t_q, acc_q, bas_q, m_q;
	logic [BW-1:0]          idx_q;
	logic                   res_q;
	logic [8:0]             base_now;
	logic                   mm_start, mm_done;
	logic [VALUE_WIDTH-1:0] mm_a, mm_b, mm_p;
	logic [9:0]             red_q;
	logic [VALUE_WIDTH:0]   red_wide;
	logic                   running_q;

	assign base_now = mrpt_pkg::base_value(idx_q);
	assign red_wide = (VALUE_WIDTH+1)'(red_q);

	mrpt_mulmod #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul (
		.clk, .arst_n,
		.start(mm_start), .a(mm_a), .b(mm_b), .m(p_q),
		.done(mm_done), .product(mm_p)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrpt_pkg::ST_IDLE:
				if (q_valid)
					state_d = (q_cls == mrpt_pkg::CLS_TEST) ? mrpt_pkg::ST_BASE
						: mrpt_pkg::ST_DONE;
			mrpt_pkg::ST_BASE:
				if (s_q != '0 && !s_q[0]) state_d = mrpt_pkg::ST_BASE;
				else if (idx_q == BW'(mrpt_pkg::NumBases)) state_d = mrpt_pkg::ST_DONE;
				else if (p_q == VALUE_WIDTH'(base_now)) state_d = mrpt_pkg::ST_DONE;
				else state_d = mrpt_pkg::ST_REDUCE;
			mrpt_pkg::ST_REDUCE:
				if (red_wide < {1'b0, p_q})
					state_d = (s_q == '0) ? mrpt_pkg::ST_CHECK
						: (s_q[0] ? mrpt_pkg::ST_EXP_MUL : mrpt_pkg::ST_EXP_SQR);
			mrpt_pkg::ST_EXP_MUL:
				if (mm_done) state_d = mrpt_pkg::ST_EXP_SQR;
			mrpt_pkg::ST_EXP_SQR:
				if (mm_done)
					state_d = (e_q[VALUE_WIDTH-1:1] == '0) ? mrpt_pkg::ST_CHECK
						: (e_q[1] ? mrpt_pkg::ST_EXP_MUL : mrpt_pkg::ST_EXP_SQR);
			mrpt_pkg::ST_CHECK:
				if (t_q != pm1_q && m_q != VALUE_WIDTH'(1) && m_q != pm1_q)
					state_d = mrpt_pkg::ST_SQR_LOOP;
				else state_d = mrpt_pkg::ST_VERDICT;
			mrpt_pkg::ST_SQR_LOOP:
				if (mm_done) state_d = mrpt_pkg::ST_CHECK;
			mrpt_pkg::ST_VERDICT:
				if (m_q != pm1_q && !t_q[0]) state_d = mrpt_pkg::ST_DONE;
				else state_d = mrpt_pkg::ST_BASE;
			mrpt_pkg::ST_DONE:
				if (out_ready) state_d = mrpt_pkg::ST_IDLE;
			default: state_d = mrpt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	logic in_mul;
	always_comb begin
		q_ready   = 1'b0;
		out_valid = 1'b0;
		mm_start  = 1'b0;
		mm_a      = acc_q;
		mm_b      = bas_q;
		in_mul    = 1'b0;
		unique case (state_q)
			mrpt_pkg::ST_IDLE:  q_ready = 1'b1;
			mrpt_pkg::ST_DONE:  out_valid = 1'b1;
			mrpt_pkg::ST_EXP_MUL: begin
				mm_a = acc_q; mm_b = bas_q; in_mul = 1'b1;
			end
			mrpt_pkg::ST_EXP_SQR: begin
				mm_a = bas_q; mm_b = bas_q; in_mul = 1'b1;
			end
			mrpt_pkg::ST_SQR_LOOP: begin
				mm_a = m_q; mm_b = m_q; in_mul = 1'b1;
			end
			default: ;
		endcase
		// launch a multiply in a multiply state whenever none is in flight
		mm_start = in_mul && !running_q;
	end

	assign out_is_prime = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mrpt_pkg::ST_IDLE;
			running_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a multiply is in flight until done
			if (mm_start) running_q <= 1'b1;
			else if (mm_done) running_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			mrpt_pkg::ST_IDLE: begin
				p_q   <= q_value;
				pm1_q <= q_value - VALUE_WIDTH'(1);
				s_q   <= q_value - VALUE_WIDTH'(1);
				idx_q <= '0;
				res_q <= (q_cls != mrpt_pkg::CLS_COMPOSITE);
			end
			mrpt_pkg::ST_BASE: begin
				// odd part: shift the trailing zero bits off, one per cycle
				if (s_q != '0 && !s_q[0]) begin
					s_q <= s_q >> 1;
				end
				red_q <= {1'b0, base_now};
				acc_q <= VALUE_WIDTH'(1);
				e_q   <= s_q >> 1;
				t_q   <= s_q;
				if (idx_q == BW'(mrpt_pkg::NumBases)) res_q <= 1'b1;
				if (p_q == VALUE_WIDTH'(base_now)) res_q <= 1'b1;
			end
			mrpt_pkg::ST_REDUCE: begin
				if (red_wide >= {1'b0, p_q})
					red_q <= 10'(red_wide - {1'b0, p_q});
				else begin
					bas_q <= VALUE_WIDTH'(red_q);
					e_q   <= s_q;
					t_q   <= s_q;
					m_q   <= VALUE_WIDTH'(1);
					acc_q <= VALUE_WIDTH'(1);
				end
			end
			mrpt_pkg::ST_EXP_MUL:
				if (mm_done) acc_q <= mm_p;
			mrpt_pkg::ST_EXP_SQR:
				if (mm_done) begin
					bas_q <= mm_p;
					e_q   <= e_q >> 1;
					if (e_q[VALUE_WIDTH-1:1] == '0) m_q <= acc_q;
				end
			mrpt_pkg::ST_CHECK:
				if (e_q == '0 && state_d == mrpt_pkg::ST_CHECK) m_q <= acc_q;
			mrpt_pkg::ST_SQR_LOOP:
				if (mm_done) begin
					m_q <= mm_p;
					t_q <= t_q << 1;
				end
			mrpt_pkg::ST_VERDICT: begin
				if (m_q != pm1_q && !t_q[0]) res_q <= 1'b0;
				idx_q <= idx_q + BW'(1);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/miller_rabin_prime_test_unit.sv @@
// Order of work: trivial candidates go from the queue straight to the result;
// odd candidates first strip the odd part, then per base run up to about 64
// multiplies and squarings on the one bit-serial multiply-reduce unit.
// Throughput: one candidate at a time in the back; the front queue holds two.
// Reset: arst_n clears the queue and the sequencer; nothing else needs it.
`default_nettype none
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_unit
// Miller-Rabin test with bases 2, 3, 5, 233 and 331 behind a small queue.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_unit #(
	parameter int unsigned VALUE_WIDTH = mrpt_pkg::ValueWidth
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mrpt_stream_if.sink   in_ch,
	mrpt_stream_if.source out_ch
);
	logic                   q_valid, q_ready;
	logic [VALUE_WIDTH-1:0] q_value;
	mrpt_pkg::cls_t         q_cls;
	logic                   res;

	mrpt_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_value(in_ch.data[VALUE_WIDTH-1:0]),
		.q_valid, .q_ready, .q_value, .q_cls
	);

	mrpt_engine #(.VALUE_WIDTH(VALUE_WIDTH)) u_engine (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_value, .q_cls,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_is_prime(res)
	);

	assign out_ch.data = res;
endmodule
`default_nettype wire
